FILE: rtl/convex_polygon_plane_clipper_core_macros.svh
// ----------------------------------------------------------------------------
// Clipper assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CONVEX_POLYGON_PLANE_CLIPPER_CORE_MACROS_SVH
`define CONVEX_POLYGON_PLANE_CLIPPER_CORE_MACROS_SVH
`ifndef SYNTH
`define CPPC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define CPPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CPPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CPPC_ASSERT_ALWAYS(lbl, expr, msg)
`define CPPC_ASSERT_IMPL(lbl, ante, cons, msg)
`define CPPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/cppc_pkg.sv
// ----------------------------------------------------------------------------
// Clipper package
// Shared constants, codes and controller/datapath word types.
// ----------------------------------------------------------------------------
package cppc_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int COORD_W        = 48;
  localparam int NORM_W         = 18;
  localparam int EPS_W          = 17;
  localparam int CFG_IDX_W      = 3;
  localparam int RATIO_BITS     = 24;
  localparam int OUT_MARGIN     = 4;

  localparam logic signed [NORM_W-1:0]  NORM_ONE     = 18'sd65536;
  localparam logic signed [NORM_W-1:0]  NORM_NEG_ONE = -18'sd65536;
  localparam logic signed [NORM_W-1:0]  NORM_X_RST   = 18'sd65536;
  localparam logic [EPS_W-1:0]          EPS_RST      = 17'd6554;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X  = 3'd0,
    REG_NORMAL_Y  = 3'd1,
    REG_NORMAL_Z  = 3'd2,
    REG_OFFSET    = 3'd3,
    REG_EPSILON   = 3'd4,
    REG_KEEP_ON   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CLIPPED   = 2'd0,
    ST_UNCHANGED = 2'd1,
    ST_CULLED    = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SIDE_ABOVE = 2'd0,
    SIDE_BELOW = 2'd1,
    SIDE_ON    = 2'd2
  } side_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_STORED,
    EMIT_PREV,
    EMIT_CROSS,
    EMIT_CULLED,
    EMIT_OVERFLOW
  } emit_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic    load;
    logic    set_ovf;
    logic    mul_en;
    axis_t   axis;
    acc_op_t acc_op;
    logic    dist_en;
    logic    classify;
    logic    clear;
    logic    rd_en;
    logic    take_first;
    logic    take_cur_mem;
    logic    take_cur_first;
    logic    advance;
    logic    div_init;
    logic    div_step;
    logic    lerp_diff;
    logic    lerp_mul;
    logic    lerp_sum;
    logic    lerp_add;
    emit_t   emit;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic ovf;
    logic keep_on;
    logic no_front;
    logic no_back;
    logic too_many;
    logic prev_kept;
    logic crossing;
  } stat_t;

endpackage

FILE: rtl/convex_polygon_plane_clipper_core.sv
// ----------------------------------------------------------------------------
// Convex polygon plane clipper
// Loads one polygon, classifies it against a plane and emits the clip result.
// ----------------------------------------------------------------------------
// One vertex is taken when start is high and busy is low. A stored vertex
// keeps busy high while one multiplier forms the three normal products and
// the distance is classified; a vertex past capacity is not stored and only
// sets the overflow flag. After the last vertex the polygon resolves: a culled
// or overflow word follows, an unchanged polygon is replayed vertex by vertex
// from the vertex memory, and a clipped polygon fetches its first vertex, then
// walks its edges, with each crossing edge passing through the serial 24-step
// ratio divider and the shared lerp multipliers. A clear state ends every
// polygon.
// Result words are shown for one cycle on result_valid and cannot be held
// off; last_out marks the final word of a polygon.
module convex_polygon_plane_clipper_core #(
  parameter int MAX_POINTS = cppc_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cppc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cppc_pkg::COORD_W-1:0]        cfg_data,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [cppc_pkg::COORD_W-1:0] vertex_x,
  input  logic signed [cppc_pkg::COORD_W-1:0] vertex_y,
  input  logic signed [cppc_pkg::COORD_W-1:0] vertex_z,
  input  logic                                last_vertex,
  output logic                                result_valid,
  output logic [1:0]                          clip_status,
  output logic signed [cppc_pkg::COORD_W-1:0] out_x,
  output logic signed [cppc_pkg::COORD_W-1:0] out_y,
  output logic signed [cppc_pkg::COORD_W-1:0] out_z,
  output logic                                last_out
);

  cppc_pkg::cmd_t                       cmd;
  cppc_pkg::stat_t                      stat;
  logic [$clog2(MAX_POINTS)-1:0]        rd_addr;
  logic [$clog2(MAX_POINTS+1)-1:0]      n_count;
  logic [$clog2(2*MAX_POINTS+cppc_pkg::OUT_MARGIN+2)-1:0] m_count;

  cppc_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_vertex (last_vertex),
    .busy        (busy),
    .stat        (stat),
    .n_count     (n_count),
    .m_count     (m_count),
    .cmd         (cmd),
    .rd_addr     (rd_addr)
  );

  cppc_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .vertex_z     (vertex_z),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .stat         (stat),
    .n_count      (n_count),
    .m_count      (m_count),
    .result_valid (result_valid),
    .clip_status  (clip_status),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .last_out     (last_out)
  );

endmodule

FILE: rtl/cppc_datapath.sv
// ----------------------------------------------------------------------------
// Clipper datapath
// Config registers, vertex stores, distance MAC, divider, lerp, result word.
// ----------------------------------------------------------------------------
module cppc_datapath #(
  parameter int MAX_POINTS = cppc_pkg::MAX_POINTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [cppc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cppc_pkg::COORD_W-1:0]           cfg_data,
  input  logic signed [cppc_pkg::COORD_W-1:0]    vertex_x,
  input  logic signed [cppc_pkg::COORD_W-1:0]    vertex_y,
  input  logic signed [cppc_pkg::COORD_W-1:0]    vertex_z,
  input  cppc_pkg::cmd_t                         cmd,
  input  logic [$clog2(MAX_POINTS)-1:0]          rd_addr,
  output cppc_pkg::stat_t                        stat,
  output logic [$clog2(MAX_POINTS+1)-1:0]        n_count,
  output logic [$clog2(2*MAX_POINTS+cppc_pkg::OUT_MARGIN+2)-1:0] m_count,
  output logic                                   result_valid,
  output logic [1:0]                             clip_status,
  output logic signed [cppc_pkg::COORD_W-1:0]    out_x,
  output logic signed [cppc_pkg::COORD_W-1:0]    out_y,
  output logic signed [cppc_pkg::COORD_W-1:0]    out_z,
  output logic                                   last_out
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int MW = $clog2(2 * MAX_POINTS + cppc_pkg::OUT_MARGIN + 2);
  localparam int CRW = cppc_pkg::COORD_W;
  localparam int VW = 3 * CRW;
  localparam int DW = CRW + 2;

  localparam logic signed [CRW-1:0] MAX48 = {1'b0, {(CRW-1){1'b1}}};
  localparam logic signed [CRW-1:0] MIN48 = {1'b1, {(CRW-1){1'b0}}};

  function automatic logic is_fb(input cppc_pkg::side_t s);
    return (s == cppc_pkg::SIDE_ABOVE) || (s == cppc_pkg::SIDE_BELOW);
  endfunction

  function automatic logic signed [CRW-1:0] sat48(input logic signed [CRW+4:0] v);
    if (v[CRW+4:CRW-1] == {6{v[CRW+4]}}) begin
      return v[CRW-1:0];
    end else if (v[CRW+4]) begin
      return MIN48;
    end else begin
      return MAX48;
    end
  endfunction

  // configuration
  logic signed [cppc_pkg::NORM_W-1:0] nrm_x, nrm_y, nrm_z;
  logic signed [CRW-1:0]              offset;
  logic [cppc_pkg::EPS_W-1:0]         eps;
  logic                               keep_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm_x   <= cppc_pkg::NORM_X_RST;
      nrm_y   <= '0;
      nrm_z   <= '0;
      offset  <= '0;
      eps     <= cppc_pkg::EPS_RST;
      keep_on <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        cppc_pkg::REG_NORMAL_X: nrm_x   <= cfg_data[cppc_pkg::NORM_W-1:0];
        cppc_pkg::REG_NORMAL_Y: nrm_y   <= cfg_data[cppc_pkg::NORM_W-1:0];
        cppc_pkg::REG_NORMAL_Z: nrm_z   <= cfg_data[cppc_pkg::NORM_W-1:0];
        cppc_pkg::REG_OFFSET:   offset  <= cfg_data;
        cppc_pkg::REG_EPSILON:  eps     <= cfg_data[cppc_pkg::EPS_W-1:0];
        cppc_pkg::REG_KEEP_ON:  keep_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // polygon counts
  logic [CW-1:0]   pcount, fcount, bcount, xcount;
  logic            ovf;
  cppc_pkg::side_t first_side, last_side, side_new;
  logic signed [CRW-1:0] dist_q;

  // vertex and distance/side stores
  logic [VW-1:0] vmem [MAX_POINTS];
  logic [DW-1:0] dmem [MAX_POINTS];
  logic [VW-1:0] vrd;
  logic [DW-1:0] drd;
  logic [IW-1:0] wr_idx;

  assign wr_idx = pcount[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vmem[wr_idx] <= {vertex_x, vertex_y, vertex_z};
    end
    if (cmd.classify) begin
      dmem[wr_idx] <= {side_new, dist_q};
    end
    if (cmd.rd_en) begin
      vrd <= vmem[rd_addr];
      drd <= dmem[rd_addr];
    end
  end

  // distance MAC
  logic signed [CRW-1:0]              vin_x, vin_y, vin_z, mul_p;
  logic signed [cppc_pkg::NORM_W-1:0] mul_n;
  logic signed [CRW+cppc_pkg::NORM_W-1:0] prod;
  logic signed [CRW+cppc_pkg::NORM_W+1:0] acc;
  logic signed [CRW+4:0]              dist_raw;
  logic signed [CRW-1:0]              eps_s;

  // walk registers
  logic signed [CRW-1:0] pvx, pvy, pvz, pd, fvx, fvy, fvz, fd, cvx, cvy, cvz, cd;
  cppc_pkg::side_t       ps, fs, cs;
  logic signed [CRW-1:0] la, lb, crx, cry, crz, neg_off, lres;

  always_comb begin
    case (cmd.axis)
      cppc_pkg::AXIS_Y: begin
        mul_p = vin_y;
        mul_n = nrm_y;
        la    = pvy;
        lb    = cvy;
      end
      cppc_pkg::AXIS_Z: begin
        mul_p = vin_z;
        mul_n = nrm_z;
        la    = pvz;
        lb    = cvz;
      end
      default: begin
        mul_p = vin_x;
        mul_n = nrm_x;
        la    = pvx;
        lb    = cvx;
      end
    endcase
  end

  assign dist_raw = $signed({acc[CRW+cppc_pkg::NORM_W+1], acc[CRW+cppc_pkg::NORM_W+1:16]})
                  - $signed({{5{offset[CRW-1]}}, offset});
  assign eps_s = $signed({{(CRW-cppc_pkg::EPS_W){1'b0}}, eps});

  always_comb begin
    if (dist_q > eps_s) begin
      side_new = cppc_pkg::SIDE_ABOVE;
    end else if (dist_q < -eps_s) begin
      side_new = cppc_pkg::SIDE_BELOW;
    end else begin
      side_new = cppc_pkg::SIDE_ON;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vin_x <= vertex_x;
      vin_y <= vertex_y;
      vin_z <= vertex_z;
    end
    if (cmd.mul_en) begin
      prod <= mul_p * mul_n;
    end
    case (cmd.acc_op)
      cppc_pkg::ACC_LOAD: acc <= {{2{prod[CRW+cppc_pkg::NORM_W-1]}}, prod};
      cppc_pkg::ACC_ADD:  acc <= acc + {{2{prod[CRW+cppc_pkg::NORM_W-1]}}, prod};
      default: ;
    endcase
    if (cmd.dist_en) begin
      dist_q <= sat48(dist_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      pcount     <= '0;
      fcount     <= '0;
      bcount     <= '0;
      xcount     <= '0;
      ovf        <= 1'b0;
      first_side <= cppc_pkg::SIDE_ON;
      last_side  <= cppc_pkg::SIDE_ON;
    end else begin
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.classify) begin
        pcount    <= pcount + CW'(1);
        last_side <= side_new;
        if (pcount == '0) begin
          first_side <= side_new;
        end
        if (side_new == cppc_pkg::SIDE_ABOVE) begin
          fcount <= fcount + CW'(1);
        end
        if (side_new == cppc_pkg::SIDE_BELOW) begin
          bcount <= bcount + CW'(1);
        end
        if (pcount != '0 && is_fb(last_side) && is_fb(side_new) && last_side != side_new) begin
          xcount <= xcount + CW'(1);
        end
      end
    end
  end

  logic          wrap_x;
  logic [MW-1:0] m_total;

  assign wrap_x  = is_fb(last_side) && is_fb(first_side) && last_side != first_side;
  assign m_total = MW'(pcount) - MW'(bcount) + MW'(xcount) + MW'(wrap_x);
  assign n_count = pcount;
  assign m_count = m_total;

  assign stat.full      = (pcount == CW'(MAX_POINTS));
  assign stat.ovf       = ovf;
  assign stat.keep_on   = keep_on;
  assign stat.no_front  = (fcount == '0);
  assign stat.no_back   = (bcount == '0);
  assign stat.too_many  = m_total > (MW'(pcount) + MW'(cppc_pkg::OUT_MARGIN));
  assign stat.prev_kept = (ps == cppc_pkg::SIDE_ABOVE) || (ps == cppc_pkg::SIDE_ON);
  assign stat.crossing  = is_fb(ps) && is_fb(cs) && ps != cs;

  always_ff @(posedge clk) begin
    if (cmd.take_first) begin
      {pvx, pvy, pvz} <= vrd;
      {fvx, fvy, fvz} <= vrd;
      pd <= drd[CRW-1:0];
      fd <= drd[CRW-1:0];
      ps <= cppc_pkg::side_t'(drd[DW-1:CRW]);
      fs <= cppc_pkg::side_t'(drd[DW-1:CRW]);
    end else if (cmd.advance) begin
      pvx <= cvx;
      pvy <= cvy;
      pvz <= cvz;
      pd  <= cd;
      ps  <= cs;
    end
    if (cmd.take_cur_mem) begin
      {cvx, cvy, cvz} <= vrd;
      cd <= drd[CRW-1:0];
      cs <= cppc_pkg::side_t'(drd[DW-1:CRW]);
    end else if (cmd.take_cur_first) begin
      cvx <= fvx;
      cvy <= fvy;
      cvz <= fvz;
      cd  <= fd;
      cs  <= fs;
    end
  end

  // crossing ratio, restoring division one bit per cycle
  logic [CRW+1:0] div_r, div_r2;
  logic [CRW:0]   div_b;
  logic [cppc_pkg::RATIO_BITS-1:0] q;
  logic           div_ge;

  assign div_r2 = {div_r[CRW:0], 1'b0};
  assign div_ge = div_r2 >= {1'b0, div_b};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_r <= {2'b00, (pd[CRW-1] ? -pd : pd)};
      div_b <= (pd >= cd) ? CRW'(pd - cd) + {pd[CRW-1] & ~cd[CRW-1], {CRW{1'b0}}}
                          : CRW'(cd - pd) + {cd[CRW-1] & ~pd[CRW-1], {CRW{1'b0}}};
      q     <= '0;
    end else if (cmd.div_step) begin
      div_r <= div_ge ? div_r2 - {1'b0, div_b} : div_r2;
      q     <= {q[cppc_pkg::RATIO_BITS-2:0], div_ge};
    end
  end

  // interpolation
  logic signed [CRW:0] ld_fwd, ld_bwd;
  logic [CRW:0]        lmag;
  logic                lneg;
  logic [CRW:0]        mh;
  logic [CRW-1:0]      ml;
  logic [CRW+1:0]      psum, a50;
  logic [CRW+1:0]      r50;
  logic signed [cppc_pkg::NORM_W-1:0] ln;

  assign ld_fwd = $signed({lb[CRW-1], lb}) - $signed({la[CRW-1], la});
  assign ld_bwd = $signed({la[CRW-1], la}) - $signed({lb[CRW-1], lb});
  assign a50    = {{2{la[CRW-1]}}, la};
  assign r50    = lneg ? a50 - psum : a50 + psum;
  assign neg_off = (offset == MIN48) ? MAX48 : -offset;
  assign ln = (cmd.axis == cppc_pkg::AXIS_Y) ? nrm_y :
              (cmd.axis == cppc_pkg::AXIS_Z) ? nrm_z : nrm_x;

  always_comb begin
    if (ln == cppc_pkg::NORM_ONE) begin
      lres = offset;
    end else if (ln == cppc_pkg::NORM_NEG_ONE) begin
      lres = neg_off;
    end else begin
      lres = r50[CRW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lerp_diff) begin
      lneg <= ld_fwd[CRW];
      lmag <= ld_fwd[CRW] ? ld_bwd : ld_fwd;
    end
    if (cmd.lerp_mul) begin
      mh <= lmag[CRW:cppc_pkg::RATIO_BITS] * q;
      ml <= lmag[cppc_pkg::RATIO_BITS-1:0] * q;
    end
    if (cmd.lerp_sum) begin
      psum <= (CRW+2)'(mh) + (CRW+2)'(ml[CRW-1:cppc_pkg::RATIO_BITS]);
    end
    if (cmd.lerp_add) begin
      case (cmd.axis)
        cppc_pkg::AXIS_Y: cry <= lres;
        cppc_pkg::AXIS_Z: crz <= lres;
        default:          crx <= lres;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.emit != cppc_pkg::EMIT_NONE);
    end
    last_out <= cmd.last;
    case (cmd.emit)
      cppc_pkg::EMIT_STORED: begin
        clip_status <= cppc_pkg::ST_UNCHANGED;
        {out_x, out_y, out_z} <= vrd;
      end
      cppc_pkg::EMIT_PREV: begin
        clip_status <= cppc_pkg::ST_CLIPPED;
        out_x <= pvx;
        out_y <= pvy;
        out_z <= pvz;
      end
      cppc_pkg::EMIT_CROSS: begin
        clip_status <= cppc_pkg::ST_CLIPPED;
        out_x <= crx;
        out_y <= cry;
        out_z <= crz;
      end
      cppc_pkg::EMIT_CULLED: begin
        clip_status <= cppc_pkg::ST_CULLED;
        out_x <= '0;
        out_y <= '0;
        out_z <= '0;
      end
      cppc_pkg::EMIT_OVERFLOW: begin
        clip_status <= cppc_pkg::ST_OVERFLOW;
        out_x <= '0;
        out_y <= '0;
        out_z <= '0;
      end
      default: ;
    endcase
  end

`include "convex_polygon_plane_clipper_core_macros.svh"

`CPPC_ASSERT_ALWAYS(a_count_bound, pcount <= CW'(MAX_POINTS), "vertex count past capacity")
`CPPC_ASSERT_ALWAYS(a_side_counts, (CW+1)'(fcount) + (CW+1)'(bcount) <= (CW+1)'(pcount), "side counts exceed vertex count")
`CPPC_ASSERT_IMPL(a_flag_word, result_valid && (clip_status == cppc_pkg::ST_CULLED || clip_status == cppc_pkg::ST_OVERFLOW), last_out && out_x == '0 && out_y == '0 && out_z == '0, "flag word not final or not zero")

endmodule

FILE: rtl/cppc_ctrl.sv
// ----------------------------------------------------------------------------
// Clipper controller
// Sequences vertex load, polygon resolve and the output walks.
// ----------------------------------------------------------------------------
module cppc_ctrl #(
  parameter int MAX_POINTS = cppc_pkg::MAX_POINTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   last_vertex,
  output logic                                   busy,
  input  cppc_pkg::stat_t                        stat,
  input  logic [$clog2(MAX_POINTS+1)-1:0]        n_count,
  input  logic [$clog2(2*MAX_POINTS+cppc_pkg::OUT_MARGIN+2)-1:0] m_count,
  output cppc_pkg::cmd_t                         cmd,
  output logic [$clog2(MAX_POINTS)-1:0]          rd_addr
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int MW = $clog2(2 * MAX_POINTS + cppc_pkg::OUT_MARGIN + 2);
  localparam int BW = $clog2(cppc_pkg::RATIO_BITS);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_X, S_MUL_Y, S_MUL_Z, S_ACC, S_DIST, S_CLASS, S_RESOLVE,
    S_U_RD, S_U_OUT, S_C_RD0, S_C_LD0, S_C_RD, S_C_GET, S_C_VERT,
    S_C_DIV_INIT, S_C_DIV, S_L_DIFF, S_L_MUL, S_L_SUM, S_L_ADD,
    S_C_CROSS, S_C_NEXT, S_FIN
  } state_t;

  state_t            state;
  logic [IW-1:0]     idx;
  logic [MW-1:0]     oc;
  logic [BW-1:0]     bit_cnt;
  cppc_pkg::axis_t   axis;
  logic              last_flag;

  logic [CW-1:0]     idx_inc;
  logic [MW-1:0]     oc_inc;
  logic              more;
  logic              res_unch, res_flag;

  assign idx_inc  = CW'(idx) + CW'(1);
  assign oc_inc   = oc + MW'(1);
  assign more     = idx_inc < n_count;
  assign res_unch = (stat.keep_on && stat.no_front && stat.no_back)
                  || (!stat.no_front && stat.no_back);
  assign res_flag = stat.ovf || (!res_unch && (stat.no_front || stat.too_many));
  assign busy     = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      oc        <= '0;
      bit_cnt   <= '0;
      axis      <= cppc_pkg::AXIS_X;
      last_flag <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            last_flag <= last_vertex;
            if (!stat.full) begin
              state <= S_MUL_X;
            end else if (last_vertex) begin
              state <= S_RESOLVE;
            end
          end
        end
        S_MUL_X: state <= S_MUL_Y;
        S_MUL_Y: state <= S_MUL_Z;
        S_MUL_Z: state <= S_ACC;
        S_ACC:   state <= S_DIST;
        S_DIST:  state <= S_CLASS;
        S_CLASS: state <= last_flag ? S_RESOLVE : S_IDLE;
        S_RESOLVE: begin
          idx <= '0;
          oc  <= '0;
          if (res_flag) begin
            state <= S_FIN;
          end else if (res_unch) begin
            state <= S_U_RD;
          end else begin
            state <= S_C_RD0;
          end
        end
        S_U_RD: state <= S_U_OUT;
        S_U_OUT: begin
          if (more) begin
            idx   <= idx + IW'(1);
            state <= S_U_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_C_RD0: state <= S_C_LD0;
        S_C_LD0: state <= S_C_RD;
        S_C_RD:  state <= S_C_GET;
        S_C_GET: state <= S_C_VERT;
        S_C_VERT: begin
          if (stat.prev_kept) begin
            oc <= oc_inc;
          end
          state <= stat.crossing ? S_C_DIV_INIT : S_C_NEXT;
        end
        S_C_DIV_INIT: begin
          bit_cnt <= '0;
          state   <= S_C_DIV;
        end
        S_C_DIV: begin
          if (bit_cnt == BW'(cppc_pkg::RATIO_BITS - 1)) begin
            axis  <= cppc_pkg::AXIS_X;
            state <= S_L_DIFF;
          end else begin
            bit_cnt <= bit_cnt + BW'(1);
          end
        end
        S_L_DIFF: state <= S_L_MUL;
        S_L_MUL:  state <= S_L_SUM;
        S_L_SUM:  state <= S_L_ADD;
        S_L_ADD: begin
          case (axis)
            cppc_pkg::AXIS_X: begin
              axis  <= cppc_pkg::AXIS_Y;
              state <= S_L_DIFF;
            end
            cppc_pkg::AXIS_Y: begin
              axis  <= cppc_pkg::AXIS_Z;
              state <= S_L_DIFF;
            end
            default: state <= S_C_CROSS;
          endcase
        end
        S_C_CROSS: begin
          oc    <= oc_inc;
          state <= S_C_NEXT;
        end
        S_C_NEXT: begin
          if (more) begin
            idx   <= idx + IW'(1);
            state <= S_C_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN:   state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.axis = axis;
    rd_addr  = idx;
    case (state)
      S_IDLE: begin
        cmd.load    = start && !stat.full;
        cmd.set_ovf = start && stat.full;
      end
      S_MUL_X: begin
        cmd.mul_en = 1'b1;
        cmd.axis   = cppc_pkg::AXIS_X;
      end
      S_MUL_Y: begin
        cmd.mul_en = 1'b1;
        cmd.axis   = cppc_pkg::AXIS_Y;
        cmd.acc_op = cppc_pkg::ACC_LOAD;
      end
      S_MUL_Z: begin
        cmd.mul_en = 1'b1;
        cmd.axis   = cppc_pkg::AXIS_Z;
        cmd.acc_op = cppc_pkg::ACC_ADD;
      end
      S_ACC:   cmd.acc_op   = cppc_pkg::ACC_ADD;
      S_DIST:  cmd.dist_en  = 1'b1;
      S_CLASS: cmd.classify = 1'b1;
      S_RESOLVE: begin
        if (res_flag) begin
          cmd.last = 1'b1;
          cmd.emit = (!stat.ovf && !res_unch && stat.no_front) ? cppc_pkg::EMIT_CULLED
                                                               : cppc_pkg::EMIT_OVERFLOW;
        end
      end
      S_U_RD: cmd.rd_en = 1'b1;
      S_U_OUT: begin
        cmd.emit = cppc_pkg::EMIT_STORED;
        cmd.last = !more;
      end
      S_C_RD0: begin
        cmd.rd_en = 1'b1;
        rd_addr   = '0;
      end
      S_C_LD0: cmd.take_first = 1'b1;
      S_C_RD: begin
        cmd.rd_en = more;
        rd_addr   = idx_inc[IW-1:0];
      end
      S_C_GET: begin
        cmd.take_cur_mem   = more;
        cmd.take_cur_first = !more;
      end
      S_C_VERT: begin
        if (stat.prev_kept) begin
          cmd.emit = cppc_pkg::EMIT_PREV;
          cmd.last = (oc_inc == m_count);
        end
      end
      S_C_DIV_INIT: cmd.div_init  = 1'b1;
      S_C_DIV:      cmd.div_step  = 1'b1;
      S_L_DIFF:     cmd.lerp_diff = 1'b1;
      S_L_MUL:      cmd.lerp_mul  = 1'b1;
      S_L_SUM:      cmd.lerp_sum  = 1'b1;
      S_L_ADD:      cmd.lerp_add  = 1'b1;
      S_C_CROSS: begin
        cmd.emit = cppc_pkg::EMIT_CROSS;
        cmd.last = (oc_inc == m_count);
      end
      S_C_NEXT: cmd.advance = 1'b1;
      S_FIN:    cmd.clear   = 1'b1;
      default: ;
    endcase
  end

`include "convex_polygon_plane_clipper_core_macros.svh"

`CPPC_ASSERT_ALWAYS(a_bit_range, bit_cnt < BW'(cppc_pkg::RATIO_BITS), "divider step count out of range")
`CPPC_ASSERT_IMPL(a_unch_idx, state == S_U_OUT, CW'(idx) < n_count, "unchanged walk past vertex count")
`CPPC_ASSERT_IMPL(a_cross_cnt, state == S_C_CROSS, oc < m_count, "clip walk emits more words than counted")

endmodule
